[rtl/core/ggc_pkg.sv]
package ggc_pkg;

    // Fixed field widths at the ports
    localparam int NB_W     = 12;
    localparam int COLOUR_W = 6;
    localparam int USED_W   = 7;

    // Default sizing
    localparam int DEF_MAX_NODES   = 4096;
    localparam int DEF_MAX_COLOURS = 64;

    typedef struct packed {
        logic has_neighbour;
        logic last;
        logic restart;
    } item_ctl_t;

    typedef struct packed {
        logic [NB_W-1:0]     node;
        logic [COLOUR_W-1:0] colour;
        logic [USED_W-1:0]   colours_used;
        logic                overflow;
    } result_t;

endpackage

[rtl/core/greedy_graph_colouring.sv]
// First-fit greedy vertex colouring. Nodes are coloured in index order from node
// zero; each node arrives as a run of input transactions, one per lower-numbered
// neighbour, with s_last set on the final one (an isolated node is a single
// transaction with s_has_neighbour clear). The block looks up each neighbour's
// colour in an on-chip colour memory of MAX_NODES entries, collects them in a
// used-colour bitmap and, on the last transaction, emits one result transaction
// with the node, its smallest free colour and the running colour count.
// Throughput is one input transaction per clock: the colour memory reads at
// accept, the bitmap update and first-free search finish in the following cycle,
// and a colour written there is forwarded to a read issued at the same edge.
// m_valid comes from the output register, which is loaded as a last transaction
// leaves the working stage. A last transaction can only leave the working stage
// while the output register is empty or being drained, so sustained rate follows
// m_ready. The colour memory has no reset and no clearing pass; s_restart starts
// a new graph at once.
module greedy_graph_colouring #(
    parameter int MAX_NODES   = ggc_pkg::DEF_MAX_NODES,
    parameter int MAX_COLOURS = ggc_pkg::DEF_MAX_COLOURS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input transactions
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ggc_pkg::NB_W-1:0]      s_neighbour,
    input  logic                          s_has_neighbour,
    input  logic                          s_last,
    input  logic                          s_restart,
    // result transactions
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ggc_pkg::NB_W-1:0]      m_node,
    output logic [ggc_pkg::COLOUR_W-1:0]  m_colour,
    output logic [ggc_pkg::USED_W-1:0]    m_colours_used,
    output logic                          m_overflow
);

    localparam int AW    = $clog2(MAX_NODES);
    localparam int CLR_W = $clog2(MAX_COLOURS);

    // working stage: holds the item whose neighbour colour is being read
    logic                       s1_valid_reg, s1_valid_next;
    logic [ggc_pkg::NB_W-1:0]   s1_nb_reg;
    ggc_pkg::item_ctl_t         s1_ctl_reg;
    logic                       s1_fire;
    logic                       s_accept;

    // last colour written, for a same-edge read/write hit
    logic                       fwd_valid_reg;
    logic [AW-1:0]              fwd_addr_reg;
    logic [CLR_W-1:0]           fwd_data_reg;

    // output register
    logic                       m_valid_reg, m_valid_next;
    ggc_pkg::result_t           m_res_reg;

    logic [CLR_W-1:0]           mem_rd_data;
    logic [CLR_W-1:0]           nb_colour;
    logic                       mem_wr_en;
    logic [AW-1:0]              mem_wr_addr;
    logic [CLR_W-1:0]           mem_wr_data;
    ggc_pkg::result_t           res;
    ggc_pkg::item_ctl_t         s_ctl;

    assign s_ctl.has_neighbour = s_has_neighbour;
    assign s_ctl.last          = s_last;
    assign s_ctl.restart       = s_restart;

    // a non-last item never needs the output register
    assign s1_fire  = s1_valid_reg && (!s1_ctl_reg.last || !m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign s_accept = s_valid && s_ready;

    ggc_colour_mem #(
        .DEPTH (MAX_NODES),
        .DW    (CLR_W)
    ) u_colour_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (s_accept),
        .rd_addr (AW'(s_neighbour)),
        .rd_data (mem_rd_data)
    );

    // memory returns old data when written at the read edge; the last write
    // always matches memory content, so forwarding it is always safe
    assign nb_colour = (fwd_valid_reg && (fwd_addr_reg == AW'(s1_nb_reg)))
                       ? fwd_data_reg : mem_rd_data;

    ggc_node_state #(
        .MAX_NODES   (MAX_NODES),
        .MAX_COLOURS (MAX_COLOURS)
    ) u_node_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (s1_fire),
        .ctl       (s1_ctl_reg),
        .nb        (s1_nb_reg),
        .nb_colour (nb_colour),
        .res       (res),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_fire && s1_ctl_reg.last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (mem_wr_en) begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_nb_reg  <= s_neighbour;
            s1_ctl_reg <= s_ctl;
        end
        if (mem_wr_en) begin
            fwd_addr_reg <= mem_wr_addr;
            fwd_data_reg <= mem_wr_data;
        end
        if (s1_fire && s1_ctl_reg.last) begin
            m_res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_node         = m_res_reg.node;
    assign m_colour       = m_res_reg.colour;
    assign m_colours_used = m_res_reg.colours_used;
    assign m_overflow     = m_res_reg.overflow;

    // Input held off only while the working stage is occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid_reg)
        else $error("s_ready low with empty working stage");

    // A new result appears only after a last item left the working stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_fire && s1_ctl_reg.last))
        else $error("result without a completed node");

    // Colour memory written only when a node completes
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (s1_fire && s1_ctl_reg.last))
        else $error("colour write outside node completion");

    // Pending result never overwritten while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !(s1_fire && s1_ctl_reg.last))
        else $error("stalled result overwritten");

endmodule

[rtl/core/ggc_colour_mem.sv]
module ggc_colour_mem #(
    parameter int DEPTH = ggc_pkg::DEF_MAX_NODES,
    parameter int DW    = ggc_pkg::COLOUR_W,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/ggc_node_state.sv]
module ggc_node_state #(
    parameter int MAX_NODES   = ggc_pkg::DEF_MAX_NODES,
    parameter int MAX_COLOURS = ggc_pkg::DEF_MAX_COLOURS,
    localparam int AW         = $clog2(MAX_NODES),
    localparam int CLR_W      = $clog2(MAX_COLOURS)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    fire,
    input  ggc_pkg::item_ctl_t      ctl,
    input  logic [ggc_pkg::NB_W-1:0] nb,
    input  logic [CLR_W-1:0]        nb_colour,
    output ggc_pkg::result_t        res,
    output logic                    wr_en,
    output logic [AW-1:0]           wr_addr,
    output logic [CLR_W-1:0]        wr_data
);

    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int COUNT_W = $clog2(MAX_COLOURS + 1);
    localparam int CMP_W   = (CNT_W > ggc_pkg::NB_W) ? CNT_W : ggc_pkg::NB_W;

    logic [MAX_COLOURS-1:0] bitmap_reg, bitmap_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [COUNT_W-1:0]     count_reg, count_next;

    logic [MAX_COLOURS-1:0] bm_cur, bm_new;
    logic [CNT_W-1:0]       cnt_eff;
    logic [COUNT_W-1:0]     count_eff;
    logic                   mark;
    logic                   node_ovf;
    logic                   found;
    logic [CLR_W-1:0]       free_idx;
    logic [CLR_W-1:0]       colour;
    logic [COUNT_W-1:0]     count_new;
    logic                   colour_ovf;

    // restart folds into this same item
    assign cnt_eff   = ctl.restart ? '0 : cnt_reg;
    assign count_eff = ctl.restart ? COUNT_W'(1) : count_reg;
    assign bm_cur    = ctl.restart ? '0 : bitmap_reg;

    assign mark = ctl.has_neighbour && (CMP_W'(nb) < CMP_W'(cnt_eff))
                  && (COUNT_W'(nb_colour) < COUNT_W'(MAX_COLOURS));

    always_comb begin
        bm_new = bm_cur;
        if (mark) begin
            bm_new[nb_colour] = 1'b1;
        end
    end

    // first clear bit, lowest index wins
    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = MAX_COLOURS - 1; i >= 0; i--) begin
            if (!bm_new[i]) begin
                found    = 1'b1;
                free_idx = CLR_W'(i);
            end
        end
    end

    assign node_ovf   = (cnt_eff == CNT_W'(MAX_NODES));
    assign colour_ovf = !node_ovf && !found;

    always_comb begin
        count_new = count_eff;
        if (node_ovf) begin
            colour = '0;
        end else if (!found) begin
            colour = CLR_W'(MAX_COLOURS - 1);
        end else begin
            colour = free_idx;
            if (COUNT_W'(free_idx) + COUNT_W'(1) > count_eff) begin
                count_new = COUNT_W'(free_idx) + COUNT_W'(1);
            end
        end
    end

    assign res.node         = ggc_pkg::NB_W'(cnt_eff);
    assign res.colour       = ggc_pkg::COLOUR_W'(colour);
    assign res.colours_used = ggc_pkg::USED_W'(count_new);
    assign res.overflow     = node_ovf || colour_ovf;

    assign wr_en   = fire && ctl.last && !node_ovf;
    assign wr_addr = AW'(cnt_eff);
    assign wr_data = colour;

    always_comb begin
        bitmap_next = bitmap_reg;
        cnt_next    = cnt_reg;
        count_next  = count_reg;
        if (fire) begin
            if (ctl.last) begin
                bitmap_next = '0;
                count_next  = count_new;
                cnt_next    = node_ovf ? cnt_eff : cnt_eff + CNT_W'(1);
            end else begin
                bitmap_next = bm_new;
                count_next  = count_eff;
                cnt_next    = cnt_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bitmap_reg <= '0;
            cnt_reg    <= '0;
            count_reg  <= COUNT_W'(1);
        end else begin
            bitmap_reg <= bitmap_next;
            cnt_reg    <= cnt_next;
            count_reg  <= count_next;
        end
    end

endmodule

[dv/ggc_colour_checker.sv]
`timescale 1ns / 1ps

module ggc_colour_checker #(
    parameter int MAX_NODES   = ggc_pkg::DEF_MAX_NODES,
    parameter int MAX_COLOURS = ggc_pkg::DEF_MAX_COLOURS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [ggc_pkg::NB_W-1:0]     s_neighbour,
    input  logic                         s_has_neighbour,
    input  logic                         s_last,
    input  logic                         s_restart,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [ggc_pkg::NB_W-1:0]     m_node,
    input  logic [ggc_pkg::COLOUR_W-1:0] m_colour,
    input  logic [ggc_pkg::USED_W-1:0]   m_colours_used,
    input  logic                         m_overflow,
    output int                           mismatches,
    output int                           open_results,
    output int                           results_seen,
    output int                           overflow_results
);

    int unsigned            node_colour [MAX_NODES];
    logic [MAX_COLOURS-1:0] colours_taken;
    int unsigned            next_node;
    int unsigned            colour_count;
    ggc_pkg::result_t       coloured_q[$];
    int                     fail_count   = 0;
    int                     result_count = 0;
    int                     ovf_count    = 0;

    // One accepted transaction; returns 1 when it completes a node.
    function automatic bit colour_step(input logic [ggc_pkg::NB_W-1:0] nb,
                                       input logic has_nb,
                                       input logic last, input logic restart,
                                       output ggc_pkg::result_t res);
        int unsigned pick;
        bit          no_room;
        res = '0;
        if (restart) begin
            colours_taken = '0;
            next_node     = 0;
            colour_count  = 1;
        end
        if (has_nb && nb < next_node)
            colours_taken[node_colour[nb]] = 1'b1;
        if (!last)
            return 1'b0;
        pick    = 0;
        no_room = 1'b0;
        if (next_node >= MAX_NODES) begin
            no_room = 1'b1;
        end else begin
            pick = MAX_COLOURS;
            for (int c = MAX_COLOURS - 1; c >= 0; c--)
                if (!colours_taken[c])
                    pick = c;
            if (pick == MAX_COLOURS) begin
                no_room = 1'b1;
                pick    = MAX_COLOURS - 1;
            end else if (pick + 1 > colour_count) begin
                colour_count = pick + 1;
            end
            node_colour[next_node] = pick;
        end
        res.node         = ggc_pkg::NB_W'(next_node);
        res.colour       = ggc_pkg::COLOUR_W'(pick);
        res.colours_used = ggc_pkg::USED_W'(colour_count);
        res.overflow     = no_room;
        colours_taken    = '0;
        if (next_node < MAX_NODES)
            next_node++;
        return 1'b1;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("t=%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        ggc_pkg::result_t due;
        if (!aresetn) begin
            coloured_q.delete();
            colours_taken = '0;
            next_node     = 0;
            colour_count  = 1;
        end else begin
            if (m_valid && m_ready) begin
                if (coloured_q.size() == 0) begin
                    fail_count++;
                    $display("t=%0t: result for node %0d arrived with none expected",
                             $time, m_node);
                end else begin
                    due = coloured_q.pop_front();
                    check_field("node", 32'(due.node), 32'(m_node));
                    check_field("colour", 32'(due.colour), 32'(m_colour));
                    check_field("colours_used", 32'(due.colours_used),
                                32'(m_colours_used));
                    check_field("overflow", 32'(due.overflow), 32'(m_overflow));
                    result_count++;
                    if (m_overflow)
                        ovf_count++;
                end
            end
            if (s_valid && s_ready) begin
                if (colour_step(s_neighbour, s_has_neighbour, s_last, s_restart, due))
                    coloured_q = {coloured_q, due};
            end
        end
        mismatches       <= fail_count;
        open_results     <= coloured_q.size();
        results_seen     <= result_count;
        overflow_results <= ovf_count;
    end

endmodule

[dv/greedy_graph_colouring_tb.sv]
`timescale 1ns / 1ps

module greedy_graph_colouring_tb;

    localparam int NB_W         = ggc_pkg::NB_W;
    localparam int NODES        = ggc_pkg::DEF_MAX_NODES;
    localparam int COLOURS      = ggc_pkg::DEF_MAX_COLOURS;
    localparam int IDLE_PCT     = 17;      // chance of a bubble on either side
    localparam int RANDOM_TXNS  = 680;
    localparam int CLIQUE_NODES = COLOURS / 2;
    localparam int DRAIN_CYCLES = 16;      // slack after the last expected result
    localparam int CYCLE_LIMIT  = 400000;

    logic            aclk            = 1'b0;
    logic            aresetn         = 1'b0;
    logic            s_valid         = 1'b0;
    logic            s_ready;
    logic [NB_W-1:0] s_neighbour     = '0;
    logic            s_has_neighbour = 1'b0;
    logic            s_last          = 1'b0;
    logic            s_restart       = 1'b0;
    logic            m_valid;
    logic            m_ready         = 1'b0;
    logic [NB_W-1:0]                 m_node;
    logic [ggc_pkg::COLOUR_W-1:0]    m_colour;
    logic [ggc_pkg::USED_W-1:0]      m_colours_used;
    logic                            m_overflow;

    int mismatches, open_results, results_seen, overflow_results;
    int txns_sent   = 0;
    int node_now    = 0;   // stimulus-side copy of the node counter, used to aim neighbours
    int cycle_count = 0;
    bit no_gaps     = 1'b0; // when set, neither side inserts bubbles

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    greedy_graph_colouring #(
        .MAX_NODES   (NODES),
        .MAX_COLOURS (COLOURS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_neighbour     (s_neighbour),
        .s_has_neighbour (s_has_neighbour),
        .s_last          (s_last),
        .s_restart       (s_restart),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_node          (m_node),
        .m_colour        (m_colour),
        .m_colours_used  (m_colours_used),
        .m_overflow      (m_overflow)
    );

    // Watches both channels, predicts every coloured node and compares.
    ggc_colour_checker #(
        .MAX_NODES   (NODES),
        .MAX_COLOURS (COLOURS)
    ) colour_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_neighbour      (s_neighbour),
        .s_has_neighbour  (s_has_neighbour),
        .s_last           (s_last),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_node           (m_node),
        .m_colour         (m_colour),
        .m_colours_used   (m_colours_used),
        .m_overflow       (m_overflow),
        .mismatches       (mismatches),
        .open_results     (open_results),
        .results_seen     (results_seen),
        .overflow_results (overflow_results)
    );

    // Result side back-pressure, changed on the falling edge like every input.
    always @(negedge aclk)
        m_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, open_results);
            $display("[greedy_graph_colouring] ERROR");
            $finish;
        end
    end

    // Drives one input transaction. Called and returns at a falling edge; valid is
    // held with a stable payload until the rising edge that accepts it.
    task automatic send_txn(input logic [NB_W-1:0] nb, input bit has_nb, input bit last,
                            input bit restart);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_neighbour     <= nb;
        s_has_neighbour <= has_nb;
        s_last          <= last;
        s_restart       <= restart;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
        txns_sent++;
        if (restart)
            node_now = 0;
        if (last && node_now < NODES)
            node_now++;
    endtask

    // An already coloured node, or any index at all while the graph is empty.
    function automatic logic [NB_W-1:0] lower_node();
        if (node_now == 0)
            return NB_W'($urandom);
        return NB_W'($urandom_range(node_now - 1));
    endfunction

    // One node: a run of n_nb neighbour transactions, last one flagged. With noise,
    // some transactions drop the neighbour flag, point at a node not yet coloured,
    // or restart the graph in the middle of the run.
    task automatic colour_run(input int n_nb, input bit fresh, input int noise_pct);
        logic [NB_W-1:0] nb;
        bit              has_nb;
        bit              restart;
        if (n_nb == 0) begin
            // isolated node: neighbour field carries junk that must be ignored
            send_txn(NB_W'($urandom), 1'b0, 1'b1, fresh);
            return;
        end
        for (int i = 0; i < n_nb; i++) begin
            nb      = lower_node();
            has_nb  = 1'b1;
            restart = fresh && (i == 0);
            if ($urandom_range(99) < noise_pct) begin
                case ($urandom_range(2))
                    0: has_nb = 1'b0;
                    1: nb = (node_now < NODES) ? NB_W'($urandom_range(NODES - 1, node_now))
                                               : NB_W'($urandom);
                    default: restart = 1'b1;
                endcase
            end
            send_txn(nb, has_nb, i == n_nb - 1, restart);
        end
    endtask

    initial begin
        int random_end;
        int graph_nodes;
        int n_nb;
        int off;
        bit fresh;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ---- hand-picked runs ----
        // restart on an isolated node, all-ones neighbour ignored
        send_txn(12'hFFF, 1'b0, 1'b1, 1'b1);
        send_txn(12'h000, 1'b1, 1'b1, 1'b0);          // node 1 next to 0 -> colour 1
        // node 2: index above, index equal, flag clear all ignored; then 0 and 1
        send_txn(12'hFFF, 1'b1, 1'b0, 1'b0);
        send_txn(12'h002, 1'b1, 1'b0, 1'b0);
        send_txn(12'h001, 1'b0, 1'b0, 1'b0);
        send_txn(12'h000, 1'b1, 1'b0, 1'b0);
        send_txn(12'h001, 1'b1, 1'b1, 1'b0);          // -> colour 2
        send_txn(12'h001, 1'b1, 1'b0, 1'b0);          // node 3 takes colour 0
        send_txn(12'h002, 1'b1, 1'b1, 1'b0);
        // restart in the middle of a run: the marked bit must be dropped
        send_txn(12'h000, 1'b1, 1'b0, 1'b0);
        send_txn(12'h000, 1'b1, 1'b1, 1'b1);
        // restart on a non-last transaction, then isolated node 0
        send_txn(12'h000, 1'b0, 1'b0, 1'b1);
        send_txn(12'h000, 1'b0, 1'b1, 1'b0);
        send_txn(12'h000, 1'b1, 1'b1, 1'b0);
        send_txn(12'hFFF, 1'b1, 1'b1, 1'b1);          // restart with out-of-range neighbour
        send_txn(12'h000, 1'b1, 1'b1, 1'b0);
        // duplicate neighbour in one run
        send_txn(12'h000, 1'b1, 1'b0, 1'b0);
        send_txn(12'h000, 1'b1, 1'b1, 1'b0);
        // alternating bit patterns, both far above the current node
        send_txn(12'hAAA, 1'b1, 1'b1, 1'b0);
        send_txn(12'h555, 1'b1, 1'b1, 1'b0);

        // ---- random graphs ----
        // Mostly small graphs, a few larger ones; most start with a restart, some
        // carry on from the previous graph. Stops at the transaction budget.
        random_end = txns_sent + RANDOM_TXNS;
        while (txns_sent < random_end) begin
            graph_nodes = ($urandom_range(9) == 0) ? $urandom_range(300, 60)
                                                   : $urandom_range(40, 1);
            fresh = ($urandom_range(7) != 0);
            for (int n = 0; n < graph_nodes && txns_sent < random_end; n++) begin
                n_nb = ($urandom_range(7) == 0) ? $urandom_range(node_now < 40 ? node_now : 40)
                                                : $urandom_range(5);
                colour_run(n_nb, fresh && n == 0, 10);
            end
        end

        // ---- clique ----
        // Every node is adjacent to all earlier ones, so node k gets colour k and
        // the colour count climbs by one per node. Runs with no bubbles at all.
        no_gaps = 1'b1;
        for (int n = 0; n < CLIQUE_NODES; n++) begin
            if (n == 0) begin
                send_txn(NB_W'($urandom), 1'b0, 1'b1, 1'b1);
            end else begin
                off = $urandom_range(n - 1);
                for (int i = 0; i < n; i++)
                    send_txn(NB_W'((i + off) % n), 1'b1, i == n - 1, 1'b0);
            end
        end
        no_gaps = 1'b0;

        s_valid <= 1'b0;

        // open_results is updated at the rising edge, so look at it mid-cycle
        while (open_results != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("sent %0d input transactions, checked %0d coloured nodes (%0d overflowed)",
                 txns_sent, results_seen, overflow_results);
        $display("covered hand-picked runs, random graphs with noise and a %0d-node clique",
                 CLIQUE_NODES);
        if (mismatches == 0 && open_results == 0)
            $display("[greedy_graph_colouring] OK");
        else
            $display("[greedy_graph_colouring] ERROR");
        $finish;
    end

endmodule

[greedy_graph_colouring.f]
rtl/core/ggc_pkg.sv
rtl/core/ggc_colour_mem.sv
rtl/core/ggc_node_state.sv
rtl/core/greedy_graph_colouring.sv
dv/ggc_colour_checker.sv
dv/greedy_graph_colouring_tb.sv
